// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the address-resolution table.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/arpc_pkg.sv =====
// Types and fixed constants of the address-resolution table.
// Depends on nothing; used by arp_cache_table_core and its testbench.
package arpc_pkg;

    localparam int OP_W   = 2;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int CFG_W  = 5;

    // Reset value of the capacity register before saturation to the table size.
    localparam int CAP_RESET = 16;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_LEARN  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_COPY,
        ST_WRNEW,
        ST_RMCOPY,
        ST_FIN
    } t_state;

endpackage

// ===== design/arp_cache_table_core.sv =====
// Address-resolution table: compacted entry memory with a sequential scan engine.
// Depends on arpc_pkg and assert_macros.svh.
//
//  Channel   Direction  Handshake                    Payload
//  in        input      i_in_valid / o_in_ready      i_operation, i_interface_number,
//                                                    i_ipv4_address, i_mac_in
//  out       output     o_out_valid / i_out_ready    o_found, o_mac_out, o_entry_count
//  cfg       input      i_cfg_we (no wait)           i_cfg_wdata (capacity in use)
//
// An item runs a scan of the valid entries (skipped when the table is empty), a
// decide step and a final step; a learn into a full table adds the copy and
// write-new steps for the entry move, a remove that hits adds the remove-copy step.
// The entry memory, read once per cycle during the scan, bounds how fast this runs.
// Reset is synchronous and active low; it empties the table and restores the
// capacity to sixteen slots (or the table size, if smaller).
// A finished result waits in the output register while the next item is taken;
// the engine stalls at its last step only if that register is still occupied.
`include "assert_macros.svh"

module arp_cache_table_core #(
    parameter int TABLE_ENTRIES  = 16,
    parameter int INTERFACE_BITS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [arpc_pkg::OP_W-1:0]        i_operation,
    input  logic [INTERFACE_BITS-1:0]        i_interface_number,
    input  logic [arpc_pkg::IP_W-1:0]        i_ipv4_address,
    input  logic [arpc_pkg::MAC_W-1:0]       i_mac_in,

    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [arpc_pkg::MAC_W-1:0]       o_mac_out,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_entry_count,

    input  logic                             i_cfg_we,
    input  logic [arpc_pkg::CFG_W-1:0]       i_cfg_wdata
);

    // Count width holds the table size itself; index width addresses one slot.
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CAP_INIT = (arpc_pkg::CAP_RESET > TABLE_ENTRIES) ?
                              TABLE_ENTRIES : arpc_pkg::CAP_RESET;

    typedef struct packed {
        logic [INTERFACE_BITS-1:0]  iface;
        logic [arpc_pkg::IP_W-1:0]  ip;
        logic [arpc_pkg::MAC_W-1:0] mac;
    } t_entry;

    // Entry memory: one write port, one registered read port.
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_q;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;
    logic [IDX_W-1:0] rd_addr;

    // Sequencer state and the item being worked on.
    arpc_pkg::t_state r_state, n_state;
    logic [arpc_pkg::OP_W-1:0]  r_op, n_op;
    logic [INTERFACE_BITS-1:0]  r_key_iface, n_key_iface;
    logic [arpc_pkg::IP_W-1:0]  r_key_ip, n_key_ip;
    logic [arpc_pkg::MAC_W-1:0] r_mac_in, n_mac_in;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic                       r_hit, n_hit;
    logic [IDX_W-1:0]           r_hit_idx, n_hit_idx;
    logic [arpc_pkg::MAC_W-1:0] r_hit_mac, n_hit_mac;
    logic                       r_res_found, n_res_found;
    logic [arpc_pkg::MAC_W-1:0] r_res_mac, n_res_mac;

    // Table occupancy and the capacity register.
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap;

    // Output register, parting the engine from the result consumer.
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_found, n_out_found;
    logic [arpc_pkg::MAC_W-1:0] r_out_mac, n_out_mac;
    logic [CNT_W-1:0]           r_out_count, n_out_count;

    logic in_accept;
    logic key_match;
    logic out_free;

    assign o_in_ready    = (r_state == arpc_pkg::ST_IDLE);
    assign in_accept     = i_in_valid && o_in_ready;
    assign out_free      = !r_out_valid || i_out_ready;
    assign key_match     = (r_q.iface == r_key_iface) && (r_q.ip == r_key_ip);

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_mac_out     = r_out_mac;
    assign o_entry_count = r_out_count;

    // Memory port. Writes happen only in the decide and move steps, never in a cycle
    // that also reads an entry the same item still needs, so no forwarding is required.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpc_pkg::ST_IDLE;
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_INIT);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                // Writing the capacity empties the table; values above the size saturate.
                r_count <= '0;
                if (int'(i_cfg_wdata) > TABLE_ENTRIES) begin
                    r_cap <= CNT_W'(TABLE_ENTRIES);
                end else begin
                    r_cap <= CNT_W'(i_cfg_wdata);
                end
            end else begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key_iface <= n_key_iface;
        r_key_ip    <= n_key_ip;
        r_mac_in    <= n_mac_in;
        r_idx       <= n_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_mac   <= n_hit_mac;
        r_res_found <= n_res_found;
        r_res_mac   <= n_res_mac;
        r_out_found <= n_out_found;
        r_out_mac   <= n_out_mac;
        r_out_count <= n_out_count;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key_iface = r_key_iface;
        n_key_ip    = r_key_ip;
        n_mac_in    = r_mac_in;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_mac   = r_hit_mac;
        n_res_found = r_res_found;
        n_res_mac   = r_res_mac;
        n_count     = r_count;
        n_out_found = r_out_found;
        n_out_mac   = r_out_mac;
        n_out_count = r_out_count;
        n_out_valid = r_out_valid && !i_out_ready;

        rd_addr     = '0;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '{iface: r_key_iface, ip: r_key_ip, mac: r_mac_in};

        case (r_state)
            arpc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_op        = i_operation;
                    n_key_iface = i_interface_number;
                    n_key_ip    = i_ipv4_address;
                    n_mac_in    = i_mac_in;
                    n_idx       = '0;
                    n_hit       = 1'b0;
                    rd_addr     = '0;
                    // An empty table has nothing to scan.
                    n_state     = (r_count == '0) ? arpc_pkg::ST_DECIDE : arpc_pkg::ST_SCAN;
                end
            end

            arpc_pkg::ST_SCAN: begin
                // r_q holds slot r_idx; the read of the next slot is issued alongside.
                if (key_match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                    n_hit_mac = r_q.mac;
                    n_state   = arpc_pkg::ST_DECIDE;
                end else if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                    n_state   = arpc_pkg::ST_DECIDE;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    rd_addr   = r_idx + 1'b1;
                end
            end

            arpc_pkg::ST_DECIDE: begin
                n_state     = arpc_pkg::ST_FIN;
                n_res_found = 1'b0;
                n_res_mac   = '0;
                case (r_op)
                    arpc_pkg::OP_LEARN: begin
                        if (r_cap != '0) begin
                            n_res_mac = r_mac_in;
                            if (r_hit) begin
                                // Update the MAC of the matching entry.
                                n_res_found = 1'b1;
                                mem_we      = 1'b1;
                                mem_wa      = r_hit_idx;
                            end else if (r_count < r_cap) begin
                                // Append behind the last valid entry.
                                mem_we  = 1'b1;
                                mem_wa  = IDX_W'(r_count);
                                n_count = r_count + 1'b1;
                            end else begin
                                // Full: fetch the last slot so that slot 0 can take it.
                                rd_addr = IDX_W'(r_cap - CNT_W'(1));
                                n_state = arpc_pkg::ST_COPY;
                            end
                        end
                    end
                    arpc_pkg::OP_REMOVE: begin
                        if (r_hit) begin
                            // Fetch the last valid entry to fill the freed slot.
                            n_res_found = 1'b1;
                            n_count     = r_count - 1'b1;
                            rd_addr     = IDX_W'(r_count - CNT_W'(1));
                            n_state     = arpc_pkg::ST_RMCOPY;
                        end
                    end
                    default: begin
                        // Lookup; the unused operation code behaves the same way.
                        n_res_found = r_hit;
                        n_res_mac   = r_hit ? r_hit_mac : '0;
                    end
                endcase
            end

            arpc_pkg::ST_COPY: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = r_q;
                n_state = arpc_pkg::ST_WRNEW;
            end

            arpc_pkg::ST_WRNEW: begin
                mem_we  = 1'b1;
                mem_wa  = IDX_W'(r_cap - CNT_W'(1));
                n_count = r_cap;
                n_state = arpc_pkg::ST_FIN;
            end

            arpc_pkg::ST_RMCOPY: begin
                mem_we  = 1'b1;
                mem_wa  = r_hit_idx;
                mem_wd  = r_q;
                n_state = arpc_pkg::ST_FIN;
            end

            arpc_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_mac   = r_res_mac;
                    n_out_count = r_count;
                    n_state     = arpc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // The table never holds more entries than the capacity allows.
    `ASSERT_IMPL(a_count_le_cap, i_clk, i_rst_n, 1'b1, r_count <= r_cap)

    // The scan only ever looks at valid slots.
    `ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n, r_state == arpc_pkg::ST_SCAN,
        CNT_W'(r_idx) < r_count)

    // A new result appears only when the sequencer hands one over.
    `ASSERT_IMPL(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == arpc_pkg::ST_FIN)

    // The entry memory is written only by the decide and move steps.
    `ASSERT_IMPL(a_write_states, i_clk, i_rst_n, mem_we,
        r_state == arpc_pkg::ST_DECIDE || r_state == arpc_pkg::ST_COPY ||
        r_state == arpc_pkg::ST_WRNEW || r_state == arpc_pkg::ST_RMCOPY)

endmodule

// ===== tb/tb_arp_cache_table_core.sv =====
// Self-checking testbench for arp_cache_table_core, the address-resolution table.
// Depends on arpc_pkg and the RTL; drives lookups, learns and removes and checks every result.
module tb_arp_cache_table_core;

    // The package names three operations. The fourth code is legal on the port and
    // the block must treat it as a lookup that leaves the table alone.
    localparam logic [arpc_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int SLOTS          = 16;
    localparam int POOL_MAX       = 24;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 95;
    // The slowest item is a full scan plus a move. The receiver stalls rarely, so a
    // run without any handshake that reaches QUIET_LIMIT means a hang.
    localparam int QUIET_LIMIT    = 5000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CAPACITY
    } t_row_kind;

    typedef struct packed {
        logic [arpc_pkg::OP_W-1:0]  op;
        logic [3:0]                 iface;
        logic [arpc_pkg::IP_W-1:0]  ip;
        logic [arpc_pkg::MAC_W-1:0] mac;
    } t_arp_request;

    typedef struct packed {
        logic                       found;
        logic [arpc_pkg::MAC_W-1:0] mac;
        logic [4:0]                 count;
    } t_arp_answer;

    // One line of the directed script. A row either writes the capacity register or
    // sends one item; an item row may carry the answer typed in by hand.
    typedef struct packed {
        t_row_kind    kind;
        logic [4:0]   capacity;
        t_arp_request rq;
        logic         typed;
        t_arp_answer  ans;
    } t_script_row;

    logic                         i_clk              = 1'b0;
    logic                         i_rst_n            = 1'b0;
    logic                         i_in_valid         = 1'b0;
    logic                         o_in_ready;
    logic [arpc_pkg::OP_W-1:0]    i_operation        = arpc_pkg::OP_LOOKUP;
    logic [3:0]                   i_interface_number = '0;
    logic [arpc_pkg::IP_W-1:0]    i_ipv4_address     = '0;
    logic [arpc_pkg::MAC_W-1:0]   i_mac_in           = '0;
    logic                         o_out_valid;
    logic                         i_out_ready        = 1'b0;
    logic                         o_found;
    logic [arpc_pkg::MAC_W-1:0]   o_mac_out;
    logic [4:0]                   o_entry_count;
    logic                         i_cfg_we           = 1'b0;
    logic [arpc_pkg::CFG_W-1:0]   i_cfg_wdata        = '0;

    // Shadow copy of the table, kept packed in slots 0 .. tbl_count-1 exactly
    // as the block keeps it, so that eviction and removal moves line up.
    logic [3:0]                 tbl_iface [SLOTS];
    logic [arpc_pkg::IP_W-1:0]  tbl_ip    [SLOTS];
    logic [arpc_pkg::MAC_W-1:0] tbl_mac   [SLOTS];
    int                         tbl_count;
    int                         tbl_capacity;

    t_arp_answer pending_answers[$];
    t_script_row script_rows[$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int in_idle_pct  = 12;
    int out_idle_pct = 12;

    arp_cache_table_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_interface_number (i_interface_number),
        .i_ipv4_address     (i_ipv4_address),
        .i_mac_in           (i_mac_in),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found            (o_found),
        .o_mac_out          (o_mac_out),
        .o_entry_count      (o_entry_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // Resolves one item against the shadow table, applies its side effects, and
    // returns what the block must answer. The lowest matching slot wins.
    function automatic t_arp_answer resolve_and_update(input t_arp_request rq);
        int          hit;
        int          i;
        t_arp_answer ans;
        hit = -1;
        ans = '0;
        for (i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_iface[i] == rq.iface && tbl_ip[i] == rq.ip) begin
                hit = i;
            end
        end
        if (rq.op == arpc_pkg::OP_LEARN) begin
            // With no capacity a learn is dropped and answers all zero.
            if (tbl_capacity != 0) begin
                if (hit >= 0) begin
                    tbl_mac[hit] = rq.mac;
                    ans.found    = 1'b1;
                end else begin
                    // A full table evicts slot 0: the last entry moves down into it
                    // and the new entry takes the last slot.
                    if (tbl_count >= tbl_capacity) begin
                        tbl_count    = tbl_capacity - 1;
                        tbl_iface[0] = tbl_iface[tbl_count];
                        tbl_ip[0]    = tbl_ip[tbl_count];
                        tbl_mac[0]   = tbl_mac[tbl_count];
                    end
                    tbl_iface[tbl_count] = rq.iface;
                    tbl_ip[tbl_count]    = rq.ip;
                    tbl_mac[tbl_count]   = rq.mac;
                    tbl_count++;
                end
                ans.mac = rq.mac;
            end
        end else if (rq.op == arpc_pkg::OP_REMOVE) begin
            // The last entry fills the hole, so the table stays packed.
            if (hit >= 0) begin
                tbl_count--;
                tbl_iface[hit] = tbl_iface[tbl_count];
                tbl_ip[hit]    = tbl_ip[tbl_count];
                tbl_mac[hit]   = tbl_mac[tbl_count];
                ans.found      = 1'b1;
            end
        end else if (hit >= 0) begin
            // Lookup, and the reserved code that behaves like one.
            ans.found = 1'b1;
            ans.mac   = tbl_mac[hit];
        end
        ans.count = tbl_count[4:0];
        return ans;
    endfunction

    // Presents one item and holds it until the block takes it. Valid is left high on
    // return; the next call either replaces the payload in place or drops valid
    // for an idle gap, so valid is never lowered and raised in the same step.
    task automatic send_request(input t_arp_request rq, input logic typed,
                                input t_arp_answer typed_ans);
        t_arp_answer predicted;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < in_idle_pct) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_operation        <= rq.op;
        i_interface_number <= rq.iface;
        i_ipv4_address     <= rq.ip;
        i_mac_in           <= rq.mac;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // The item was taken at this edge; its answer cannot come out before the
        // scan has run, so queuing it now keeps the order of acceptance.
        predicted = resolve_and_update(rq);
        pending_answers.push_back(typed ? typed_ans : predicted);
    endtask

    // Stops sending and waits until every answer has been collected. Every item
    // gives exactly one answer, so an empty queue means the engine is idle.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // The capacity register is only touched while the block is idle. Writing it
    // empties the table; values above the table size saturate.
    task automatic set_capacity(input logic [arpc_pkg::CFG_W-1:0] value);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        tbl_capacity = (value > SLOTS) ? SLOTS : value;
        tbl_count    = 0;
    endtask

    task automatic add_item(input logic [arpc_pkg::OP_W-1:0] op, input logic [3:0] iface,
                            input logic [arpc_pkg::IP_W-1:0] ip,
                            input logic [arpc_pkg::MAC_W-1:0] mac,
                            input logic typed, input logic found,
                            input logic [arpc_pkg::MAC_W-1:0] mac_out,
                            input logic [4:0] count);
        t_script_row row;
        row.kind      = ROW_ITEM;
        row.capacity  = '0;
        row.rq.op     = op;
        row.rq.iface  = iface;
        row.rq.ip     = ip;
        row.rq.mac    = mac;
        row.typed     = typed;
        row.ans.found = found;
        row.ans.mac   = mac_out;
        row.ans.count = count;
        script_rows.push_back(row);
    endtask

    task automatic add_capacity(input logic [4:0] value);
        t_script_row row;
        row          = '0;
        row.kind     = ROW_CAPACITY;
        row.capacity = value;
        script_rows.push_back(row);
    endtask

    // The receiver and the checker. Outputs are sampled at the rising edge, before
    // any nonblocking update of that edge lands, so sampling is free of races.
    always @(posedge i_clk) begin : answer_monitor
        t_arp_answer want;
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no item pending", {63'd0, o_found}, 64'd0);
            end else begin
                want = pending_answers.pop_front();
                if (o_found !== want.found) begin
                    report_mismatch("found", {63'd0, o_found}, {63'd0, want.found});
                end
                if (o_mac_out !== want.mac) begin
                    report_mismatch("mac_out", {16'd0, o_mac_out}, {16'd0, want.mac});
                end
                if (o_entry_count !== want.count) begin
                    report_mismatch("entry_count", {59'd0, o_entry_count},
                                    {59'd0, want.count});
                end
            end
        end
    end

    initial begin : stimulus
        logic [3:0]                pool_iface [POOL_MAX];
        logic [arpc_pkg::IP_W-1:0] pool_ip    [POOL_MAX];
        int                        phase_caps [PHASES];
        int                        pool_size;
        int                        ph;
        int                        n;
        int                        k;
        int                        r;
        int                        cap;
        t_arp_request              rq;
        t_script_row               row;

        phase_caps = '{31, 1, 16, 3, 0, 16, 17, 2, 9, 16};

        tbl_count    = 0;
        tbl_capacity = SLOTS;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script. Right after reset the table is empty and holds sixteen
        // slots. The answers are easy to follow by hand, so most rows carry them.
        add_item(arpc_pkg::OP_LOOKUP, 4'h0, 32'h0000_0000, 48'h0, 1, 0, 48'h0, 5'd0);
        add_item(arpc_pkg::OP_REMOVE, 4'hF, 32'hFFFF_FFFF, 48'h0, 1, 0, 48'h0, 5'd0);
        add_item(arpc_pkg::OP_LEARN, 4'hF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 0,
                 48'hFFFF_FFFF_FFFF, 5'd1);
        add_item(arpc_pkg::OP_LEARN, 4'h0, 32'h0000_0000, 48'h0, 1, 0, 48'h0, 5'd2);
        add_item(arpc_pkg::OP_LOOKUP, 4'hF, 32'hFFFF_FFFF, 48'h0, 1, 1,
                 48'hFFFF_FFFF_FFFF, 5'd2);
        // A learn on a key already present rewrites the MAC in place.
        add_item(arpc_pkg::OP_LEARN, 4'hF, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 1, 1,
                 48'h0123_4567_89AB, 5'd2);
        // Same address on another interface is a different key.
        add_item(arpc_pkg::OP_LOOKUP, 4'h0, 32'hFFFF_FFFF, 48'h0, 1, 0, 48'h0, 5'd2);
        add_item(OP_RESERVED, 4'h0, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1, 1, 48'h0, 5'd2);
        add_item(arpc_pkg::OP_LEARN, 4'h5, 32'hC0A8_0001, 48'hAAAA_5555_AAAA, 1, 0,
                 48'hAAAA_5555_AAAA, 5'd3);
        // Removing the middle entry pulls the last one down into its slot.
        add_item(arpc_pkg::OP_REMOVE, 4'h0, 32'h0000_0000, 48'h0, 1, 1, 48'h0, 5'd2);
        add_item(arpc_pkg::OP_LOOKUP, 4'h5, 32'hC0A8_0001, 48'h0, 1, 1,
                 48'hAAAA_5555_AAAA, 5'd2);
        add_item(arpc_pkg::OP_REMOVE, 4'hF, 32'hFFFF_FFFF, 48'h0, 1, 1, 48'h0, 5'd1);
        add_item(arpc_pkg::OP_REMOVE, 4'hF, 32'hFFFF_FFFF, 48'h0, 1, 0, 48'h0, 5'd1);
        add_item(OP_RESERVED, 4'h5, 32'hC0A8_0001, 48'h0, 1, 1,
                 48'hAAAA_5555_AAAA, 5'd1);
        // Two slots: the third learn evicts the oldest entry from slot 0.
        add_capacity(5'd2);
        add_item(arpc_pkg::OP_LEARN, 4'h1, 32'h0A00_0001, 48'h111, 1, 0, 48'h111, 5'd1);
        add_item(arpc_pkg::OP_LEARN, 4'h2, 32'h0A00_0002, 48'h222, 1, 0, 48'h222, 5'd2);
        add_item(arpc_pkg::OP_LEARN, 4'h3, 32'h0A00_0003, 48'h333, 1, 0, 48'h333, 5'd2);
        add_item(arpc_pkg::OP_LOOKUP, 4'h1, 32'h0A00_0001, 48'h0, 1, 0, 48'h0, 5'd2);
        add_item(arpc_pkg::OP_LOOKUP, 4'h2, 32'h0A00_0002, 48'h0, 1, 1, 48'h222, 5'd2);
        // No capacity: a learn is dropped and answers all zero.
        add_capacity(5'd0);
        add_item(arpc_pkg::OP_LEARN, 4'h7, 32'h0000_0001, 48'h777, 1, 0, 48'h0, 5'd0);
        add_item(arpc_pkg::OP_LOOKUP, 4'h7, 32'h0000_0001, 48'h0, 1, 0, 48'h0, 5'd0);
        // The largest register value saturates to the table size.
        add_capacity(5'd31);
        add_item(arpc_pkg::OP_LEARN, 4'hA, 32'h8000_0000, 48'h8000_0000_0001, 0, 0,
                 48'h0, 5'd0);
        add_item(arpc_pkg::OP_LOOKUP, 4'hA, 32'h8000_0000, 48'h0, 0, 0, 48'h0, 5'd0);

        foreach (script_rows[i]) begin
            row = script_rows[i];
            if (row.kind == ROW_CAPACITY) begin
                set_capacity(row.capacity);
            end else begin
                send_request(row.rq, row.typed, row.ans);
            end
        end

        // Random part. Each phase sets a capacity, which empties the table, and
        // draws keys mostly from a small pool slightly larger than the capacity so
        // that hits, updates, removals and evictions all happen often.
        for (ph = 0; ph < PHASES; ph++) begin
            cap = (ph == 8) ? $urandom_range(0, 31) : phase_caps[ph];
            set_capacity(cap[4:0]);
            // One phase runs with both sides always willing.
            in_idle_pct  = (ph == 5) ? 0 : 12;
            out_idle_pct = (ph == 5) ? 0 : 12;

            pool_size = ((cap > SLOTS) ? SLOTS : cap) + 4;
            if (pool_size > POOL_MAX) pool_size = POOL_MAX;
            for (k = 0; k < pool_size; k++) begin
                r = $urandom_range(0, 3);
                pool_iface[k] = 4'($urandom_range(0, 15));
                pool_ip[k]    = $urandom;
                // Some keys share one half with the previous key, so that a match on
                // the interface alone or on the address alone is tried.
                if (k > 0 && r == 0) pool_ip[k] = pool_ip[k-1];
                if (k > 0 && r == 1) pool_iface[k] = pool_iface[k-1];
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    rq.op = arpc_pkg::OP_LEARN;
                end else if (r < 75) begin
                    rq.op = arpc_pkg::OP_LOOKUP;
                end else if (r < 95) begin
                    rq.op = arpc_pkg::OP_REMOVE;
                end else begin
                    rq.op = OP_RESERVED;
                end

                k = $urandom_range(0, pool_size - 1);
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    rq.iface = pool_iface[k];
                    rq.ip    = pool_ip[k];
                end else if (r < 92) begin
                    rq.iface = 4'($urandom_range(0, 15));
                    rq.ip    = pool_ip[k];
                end else begin
                    rq.iface = 4'($urandom_range(0, 15));
                    rq.ip    = $urandom;
                end

                r = $urandom_range(0, 9);
                if (r == 0) begin
                    rq.mac = '0;
                end else if (r == 1) begin
                    rq.mac = '1;
                end else begin
                    rq.mac = arpc_pkg::MAC_W'({$urandom, $urandom});
                end

                send_request(rq, 1'b0, '0);
            end
        end

        // Collect the last answers, then give the block time to show any stray one.
        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
